@@ rtl/core/fifo_queue_with_search_top_defines.svh @@
// ---------------------------------------------------------------------------
// fifo_queue_with_search_top_defines.svh
// Assertion macros shared by the queue RTL. Empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define FQS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fqs assertion failed");
// check that a condition implies a consequence on the same edge
`define FQS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqs implication failed");
`else
`define FQS_ASSERT(label, clk, rst, prop)
`define FQS_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/fqs_pkg.sv @@
// ---------------------------------------------------------------------------
// fqs_pkg
// Operation and status codes, sequencer states and the result word type.
// ---------------------------------------------------------------------------
package fqs_pkg;

   // operation codes
   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_SEARCH = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         position;
      logic signed [31:0] head_value;
      logic [4:0]         occupancy;
   } result_type;

endpackage

@@ rtl/core/fqs_mem.sv @@
// ---------------------------------------------------------------------------
// fqs_mem
// Queue storage: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fqs_mem #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   // write the word at the tail slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fqs_ctrl.sv @@
// ---------------------------------------------------------------------------
// fqs_ctrl
// Sequencer: pointers, count, head word and the shared equality compare
// that walks the queue one entry per cycle during a search.
// ---------------------------------------------------------------------------
`include "fifo_queue_with_search_top_defines.svh"

module fqs_ctrl
   import fqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_func,
   input  logic signed [31:0]       req_value,
   output logic                     res_valid,
   input  logic                     res_ready,
   output result_type               res,
   output logic                     mem_we,
   output logic [$clog2(DEPTH)-1:0] mem_waddr,
   output logic [31:0]              mem_wdata,
   output logic [$clog2(DEPTH)-1:0] mem_raddr,
   input  logic [31:0]              mem_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   state_type          state_ff, state_in;
   logic [AW-1:0]      head_idx_ff, head_idx_in;
   logic [AW-1:0]      tail_idx_ff, tail_idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        head_val_ff, head_val_in;
   logic [31:0]        value_ff, value_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [1:0]         stat_ff, stat_in;
   logic [4:0]         pos_ff, pos_in;
   logic [31:0]        pos_wide;
   logic [31:0]        occ_wide;
   logic               hit;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
      return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   // shared compare unit
   assign hit      = (mem_rdata == value_ff);
   assign pos_wide = 32'(k_ff) + 32'd1;
   assign occ_wide = 32'(count_ff);

   // state register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_idx_ff <= '0;
         tail_idx_ff <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         head_idx_ff <= head_idx_in;
         tail_idx_ff <= tail_idx_in;
         count_ff    <= count_in;
      end
   end

   // payload and search registers
   always_ff @(posedge clock) begin
      head_val_ff <= head_val_in;
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      k_ff        <= k_in;
      stat_ff     <= stat_in;
      pos_ff      <= pos_in;
   end

   // next state, pointer updates and memory access
   always_comb begin
      state_in    = state_ff;
      head_idx_in = head_idx_ff;
      tail_idx_in = tail_idx_ff;
      count_in    = count_ff;
      head_val_in = head_val_ff;
      value_in    = value_ff;
      slot_in     = slot_ff;
      k_in        = k_ff;
      stat_in     = stat_ff;
      pos_in      = pos_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = tail_idx_ff;
      mem_wdata   = req_value;
      mem_raddr   = next_slot(head_idx_ff);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in = req_value;
               stat_in  = STAT_OK;
               pos_in   = '0;
               state_in = ST_DONE;
               case (req_func)
                  FUNC_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        stat_in = STAT_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        tail_idx_in = next_slot(tail_idx_ff);
                        count_in    = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           head_val_in = req_value;
                        end
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        head_idx_in = next_slot(head_idx_ff);
                        count_in    = count_ff - 1'b1;
                        state_in    = ST_POP_WAIT;
                     end
                  end
                  FUNC_SEARCH: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        mem_raddr = head_idx_ff;
                        slot_in   = next_slot(head_idx_ff);
                        k_in      = '0;
                        state_in  = ST_SEARCH;
                     end
                  end
                  default: begin
                     stat_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            // take the new head word
            head_val_in = mem_rdata;
            state_in    = ST_DONE;
         end
         ST_SEARCH: begin
            if (hit) begin
               stat_in  = STAT_OK;
               pos_in   = pos_wide[4:0];
               state_in = ST_DONE;
            end else if (pos_wide == 32'(count_ff)) begin
               stat_in  = STAT_NOTFOUND;
               pos_in   = '0;
               state_in = ST_DONE;
            end else begin
               mem_raddr = slot_ff;
               slot_in   = next_slot(slot_ff);
               k_in      = k_ff + 1'b1;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result word
   assign res.status     = stat_ff;
   assign res.position   = pos_ff;
   assign res.head_value = (count_ff == '0) ? 32'sd0 : signed'(head_val_ff);
   assign res.occupancy  = occ_wide[4:0];

   `FQS_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `FQS_ASSERT_IMPL(a_search_index, clock, reset, state_ff == ST_SEARCH, k_ff < count_ff)
   `FQS_ASSERT_IMPL(a_push_count, clock, reset,
      $past(state_ff == ST_IDLE && req_valid && req_func == FUNC_PUSH && count_ff != FULL_COUNT),
      count_ff == $past(count_ff) + 1'b1)

endmodule

@@ rtl/core/fifo_queue_with_search_top.sv @@
// ---------------------------------------------------------------------------
// fifo_queue_with_search_top
// Bounded FIFO queue of signed 32-bit words with push, pop and linear search.
// ---------------------------------------------------------------------------
//  channel  direction  ports                                   word
//  req      in         req_valid/req_ready                     func, value
//  rsp      out        rsp_valid/rsp_ready                     status, position,
//                                                              head_value, occupancy
//
//  Push, unused codes and empty-queue pops or searches go straight to done;
//  a pop first reads the new head, a search compares n (1 to occupancy)
//  entries: one memory read port and one comparator visit an entry per cycle.
//  Reset (synchronous) empties the queue; storage contents are not cleared.
//  A result waiting in the output register does not block the next request;
//  the sequencer only holds at its done step until the output register frees.
// ---------------------------------------------------------------------------
module fifo_queue_with_search_top
   import fqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_position,
   output logic signed [31:0] rsp_head_value,
   output logic [4:0]         rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);

   result_type    res;
   logic          res_valid;
   logic          res_ready;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_rdata;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_word_ff, rsp_word_in;

   fqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   fqs_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // load the output register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_word_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_word_ff.status;
   assign rsp_position   = rsp_word_ff.position;
   assign rsp_head_value = rsp_word_ff.head_value;
   assign rsp_occupancy  = rsp_word_ff.occupancy;

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded FIFO queue with linear search.
// A mirror of the queue predicts the status, match position, head value and
// occupancy for every accepted request word. Each response word is compared
// field by field with the oldest prediction. Stimulus starts with a short
// directed sequence. Random fill, drain and mixed bursts follow, with random
// idle gaps on the request side and random stalls on the response side.
// ---------------------------------------------------------------------------
module tb_top;
   import fqs_pkg::*;

   localparam int QDEPTH = 16;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 1550;
   localparam int SETTLE_CYCLES = 40;

   // mirror of the queue contents and the responses it predicts
   class queue_mirror;
      logic signed [31:0] slots [QDEPTH];
      int unsigned head_slot;
      int unsigned tail_slot;
      int unsigned held;
      result_type awaited[$];
      int unsigned mismatches;

      function new();
         head_slot = 0;
         tail_slot = 0;
         held = 0;
         mismatches = 0;
      endfunction

      // apply one accepted request word and queue up its response
      function void note_request(logic [1:0] func, logic signed [31:0] value);
         result_type r;
         int unsigned slot;
         r.status = STAT_OK;
         r.position = '0;
         case (func)
            FUNC_PUSH: begin
               if (held >= QDEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  slots[tail_slot] = value;
                  tail_slot = (tail_slot + 1) % QDEPTH;
                  held++;
               end
            end
            FUNC_POP: begin
               if (held == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  head_slot = (head_slot + 1) % QDEPTH;
                  held--;
               end
            end
            FUNC_SEARCH: begin
               if (held == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.status = STAT_NOTFOUND;
                  slot = head_slot;
                  for (int k = 0; k < held; k++) begin
                     if (slots[slot] === value) begin
                        r.status = STAT_OK;
                        r.position = 5'(k + 1);
                        break;
                     end
                     slot = (slot + 1) % QDEPTH;
                  end
               end
            end
            default: ;
         endcase
         r.head_value = (held != 0) ? slots[head_slot] : '0;
         r.occupancy = 5'(held);
         awaited.push_back(r);
      endfunction

      // compare one response word with the oldest prediction
      function void check_result(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with none outstanding: st=%0d pos=%0d head=%0d occ=%0d",
                        got.status, got.position, got.head_value, got.occupancy);
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.position !== want.position ||
             got.head_value !== want.head_value || got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: st/pos/head/occ expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        want.status, want.position, want.head_value, want.occupancy,
                        got.status, got.position, got.head_value, got.occupancy);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = FUNC_PUSH;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_position;
   logic signed [31:0] rsp_head_value;
   logic [4:0]         rsp_occupancy;

   queue_mirror mirror = new();
   int unsigned words_sent = 0;
   bit          steady_send = 1'b0;

   fifo_queue_with_search_top #(
      .DEPTH(QDEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_head_value (rsp_head_value),
      .rsp_occupancy  (rsp_occupancy)
   );

   always #5 clock = ~clock;

   // check every response word taken at a clock edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.check_result('{rsp_status, rsp_position, rsp_head_value, rsp_occupancy});
   end

   // drive response back-pressure: steady stretches and random stalls
   initial begin
      int unsigned run;
      int unsigned roll;
      bit steady;
      @(posedge clock);
      forever begin
         run = $urandom_range(20, 200);
         steady = ($urandom_range(0, 3) == 0);
         repeat (run) begin
            roll = $urandom_range(0, 99);
            if (steady) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else if (roll < 3) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end else begin
               rsp_ready <= (roll >= 30);
               @(posedge clock);
            end
         end
      end
   end

   // hold one request word until it is taken
   task automatic send_word(input logic [1:0] func, input logic signed [31:0] value);
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(func, value);
      words_sent++;
   endtask

   // drop valid for a random gap, if any: mostly short and now and then long
   task automatic idle_gap();
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      if (steady_send || roll < 60)
         gap = 0;
      else if (roll < 95)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value(bit narrow);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (narrow)
         return $urandom_range(0, 7);
      if (roll < 5)
         return 32'sh7FFF_FFFF;
      if (roll < 10)
         return 32'sh8000_0000;
      return $urandom();
   endfunction

   // search mostly for held values so hits reach every position
   function automatic logic signed [31:0] pick_search(bit narrow);
      if (mirror.held != 0 && $urandom_range(0, 99) < 65)
         return mirror.slots[(mirror.head_slot + $urandom_range(0, mirror.held - 1)) % QDEPTH];
      return pick_value(narrow);
   endfunction

   task automatic random_word(int unsigned push_pct, int unsigned pop_pct, bit narrow);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         send_word(FUNC_PUSH, pick_value(narrow));
      else if (roll < push_pct + pop_pct)
         send_word(FUNC_POP, pick_value(narrow));
      else if (roll < 96)
         send_word(FUNC_SEARCH, pick_search(narrow));
      else
         send_word(FUNC_UNUSED, pick_value(narrow));
      idle_gap();
   endtask

   initial begin
      int unsigned kind;
      int unsigned len;
      bit narrow;
      int unsigned target;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty queue corner cases
      send_word(FUNC_POP, 32'sd0);
      send_word(FUNC_SEARCH, 32'sd5);
      send_word(FUNC_UNUSED, -32'sd1);
      // value extremes, then searches for hits and a miss
      send_word(FUNC_PUSH, 32'sh7FFF_FFFF);
      send_word(FUNC_PUSH, 32'sh8000_0000);
      send_word(FUNC_PUSH, 32'sd0);
      send_word(FUNC_PUSH, -32'sd1);
      send_word(FUNC_SEARCH, -32'sd1);
      send_word(FUNC_SEARCH, 32'sh8000_0000);
      send_word(FUNC_SEARCH, 32'sd12345);
      send_word(FUNC_UNUSED, 32'sd0);
      // fill to the brim with duplicates, marker at the tail slot
      for (int k = 0; k < QDEPTH - 5; k++)
         send_word(FUNC_PUSH, k % 3);
      send_word(FUNC_PUSH, 32'sh5A5A_A5A5);
      send_word(FUNC_PUSH, 32'sd77);
      send_word(FUNC_SEARCH, 32'sh5A5A_A5A5);
      send_word(FUNC_SEARCH, 32'sd1);
      send_word(FUNC_POP, 32'sd0);

      // let everything come back before the random part
      drain_responses();

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         kind = $urandom_range(0, 9);
         narrow = ($urandom_range(0, 2) == 0);
         steady_send = ($urandom_range(0, 4) == 0);
         len = $urandom_range(4, 30);
         repeat (len) begin
            if (kind < 3)
               random_word(80, 5, narrow);
            else if (kind < 6)
               random_word(10, 75, narrow);
            else
               random_word(35, 30, narrow);
         end
      end
      steady_send = 1'b0;

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
         $display("fifo_queue_with_search_top regression: pass");
      else
         $display("fifo_queue_with_search_top regression: fail");
      $finish;
   end

   // stop a hung run
   initial begin
      #8_000_000;
      $display("fifo_queue_with_search_top regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fqs_pkg.sv
rtl/core/fqs_mem.sv
rtl/core/fqs_ctrl.sv
rtl/core/fifo_queue_with_search_top.sv
tb/tb_top.sv
